// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define NRMC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nrmc: assertion failed");

// next-cycle implication, quiet while reset is held
`define NRMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nrmc: assertion failed");

// what must hold in the cycle after reset is sampled low
`define NRMC_ASSERT_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("nrmc: reset assertion failed");

`endif

// ===== rtl/core/nrmc_pkg.sv =====
// shared types, constants and helper functions of the rmc sentence parser
`default_nettype none

package nrmc_pkg;

    // fixed-point precision and sentence length
    localparam int POS_FRAC_DIGITS    = 5;
    localparam int RATE_FRAC_DIGITS   = 3;
    localparam int MAX_SENTENCE_BYTES = 256;
    localparam int POS_W              = $clog2(MAX_SENTENCE_BYTES + 1);

    localparam int NUM_W     = 34;
    localparam int NUM_SLOTS = 6;
    localparam int CHR_SLOTS = 4;
    localparam int NSLOT_W   = $clog2(NUM_SLOTS);
    localparam int CSLOT_W   = $clog2(CHR_SLOTS);
    localparam int FIELD_W   = 4;
    localparam int FRAC_W    = 3;
    localparam int DIG_W     = 4;
    localparam int WIDE_W    = NUM_W + 4;

    localparam logic [FRAC_W-1:0] POS_FRAC  = FRAC_W'(POS_FRAC_DIGITS);
    localparam logic [FRAC_W-1:0] RATE_FRAC = FRAC_W'(RATE_FRAC_DIGITS);

    localparam logic [NUM_W-1:0] MAX_LAT  = NUM_W'(64'd999999999);
    localparam logic [NUM_W-1:0] MAX_LON  = NUM_W'(64'd9999999999);
    localparam logic [NUM_W-1:0] MAX_RATE = NUM_W'(64'd9999999);

    localparam logic [DIG_W-1:0] TIME_DIGITS = DIG_W'(8);
    localparam logic [DIG_W-1:0] DATE_DIGITS = DIG_W'(6);

    localparam logic [POS_W-1:0] POS_LIMIT      = POS_W'(MAX_SENTENCE_BYTES);
    localparam logic [POS_W-1:0] HEADER_LEN     = POS_W'(6);
    localparam logic [POS_W-1:0] HEADER_MIN_END = POS_W'(5);

    // characters
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // comma field numbers
    localparam logic [FIELD_W-1:0] F_HEADER  = FIELD_W'(0);
    localparam logic [FIELD_W-1:0] F_TIME    = FIELD_W'(1);
    localparam logic [FIELD_W-1:0] F_STATUS  = FIELD_W'(2);
    localparam logic [FIELD_W-1:0] F_LAT     = FIELD_W'(3);
    localparam logic [FIELD_W-1:0] F_LAT_HEM = FIELD_W'(4);
    localparam logic [FIELD_W-1:0] F_LON     = FIELD_W'(5);
    localparam logic [FIELD_W-1:0] F_LON_HEM = FIELD_W'(6);
    localparam logic [FIELD_W-1:0] F_SPEED   = FIELD_W'(7);
    localparam logic [FIELD_W-1:0] F_HEADING = FIELD_W'(8);
    localparam logic [FIELD_W-1:0] F_DATE    = FIELD_W'(9);
    localparam logic [FIELD_W-1:0] F_MODE    = FIELD_W'(10);

    // storage slots
    localparam logic [NSLOT_W-1:0] S_TIME    = NSLOT_W'(0);
    localparam logic [NSLOT_W-1:0] S_LAT     = NSLOT_W'(1);
    localparam logic [NSLOT_W-1:0] S_LON     = NSLOT_W'(2);
    localparam logic [NSLOT_W-1:0] S_SPEED   = NSLOT_W'(3);
    localparam logic [NSLOT_W-1:0] S_HEADING = NSLOT_W'(4);
    localparam logic [NSLOT_W-1:0] S_DATE    = NSLOT_W'(5);

    localparam logic [CSLOT_W-1:0] C_STATUS  = CSLOT_W'(0);
    localparam logic [CSLOT_W-1:0] C_LAT_HEM = CSLOT_W'(1);
    localparam logic [CSLOT_W-1:0] C_LON_HEM = CSLOT_W'(2);
    localparam logic [CSLOT_W-1:0] C_MODE    = CSLOT_W'(3);

    typedef enum logic [2:0] {
        FK_HEADER,
        FK_TIME,
        FK_DATE,
        FK_DECIMAL,
        FK_CHAR
    } t_field_kind;

    // per-field conversion progress
    typedef struct packed {
        logic              point;
        logic              stop;
        logic [FRAC_W-1:0] frac_cnt;
        logic [DIG_W-1:0]  dig_cnt;
    } t_num_state;

    typedef struct packed {
        logic star_seen;
        logic sum_ok;
    } t_cks_stat;

    typedef struct packed {
        logic [31:0] time_bcd;
        logic [7:0]  fix_status;
        logic [29:0] latitude;
        logic [7:0]  lat_hemisphere;
        logic [33:0] longitude;
        logic [7:0]  lon_hemisphere;
        logic [23:0] ground_speed;
        logic [23:0] heading;
        logic [23:0] date_bcd;
        logic [7:0]  fix_mode;
    } t_record;

    typedef struct packed {
        logic    ok;
        t_record rec;
    } t_result;

    function automatic t_field_kind field_kind(input logic [FIELD_W-1:0] fn);
        t_field_kind k;
        unique case (fn)
            F_HEADER:                               k = FK_HEADER;
            F_TIME:                                 k = FK_TIME;
            F_DATE:                                 k = FK_DATE;
            F_LAT, F_LON, F_SPEED, F_HEADING:       k = FK_DECIMAL;
            default:                                k = FK_CHAR;
        endcase
        return k;
    endfunction

    function automatic logic [NSLOT_W-1:0] num_slot(input logic [FIELD_W-1:0] fn);
        logic [NSLOT_W-1:0] s;
        unique case (fn)
            F_LAT:     s = S_LAT;
            F_LON:     s = S_LON;
            F_SPEED:   s = S_SPEED;
            F_HEADING: s = S_HEADING;
            F_DATE:    s = S_DATE;
            default:   s = S_TIME;
        endcase
        return s;
    endfunction

    function automatic logic [CSLOT_W-1:0] chr_slot(input logic [FIELD_W-1:0] fn);
        logic [CSLOT_W-1:0] s;
        unique case (fn)
            F_LAT_HEM: s = C_LAT_HEM;
            F_LON_HEM: s = C_LON_HEM;
            F_MODE:    s = C_MODE;
            default:   s = C_STATUS;
        endcase
        return s;
    endfunction

    function automatic logic [FRAC_W-1:0] dec_frac(input logic [FIELD_W-1:0] fn);
        return ((fn == F_LAT) || (fn == F_LON)) ? POS_FRAC : RATE_FRAC;
    endfunction

    function automatic logic [NUM_W-1:0] dec_max(input logic [FIELD_W-1:0] fn);
        logic [NUM_W-1:0] m;
        unique case (fn)
            F_LAT:   m = MAX_LAT;
            F_LON:   m = MAX_LON;
            default: m = MAX_RATE;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24;  // '$'
            3'd1:    c = 8'h47;  // 'G'
            3'd2:    c = 8'h4E;  // 'N'
            3'd3:    c = 8'h52;  // 'R'
            3'd4:    c = 8'h4D;  // 'M'
            3'd5:    c = 8'h43;  // 'C'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [23:0] pow10(input logic [FRAC_W-1:0] k);
        logic [23:0] p;
        case (k)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nrmc_cksum.sv =====
// star detection, running xor and received checksum digits
`default_nettype none

module nrmc_cksum (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_last,
    input  wire logic               i_pos_first,
    output nrmc_pkg::t_cks_stat     o_stat
);

    logic       r_star, n_star;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_recv, n_recv;
    logic [1:0] r_hex_cnt, n_hex_cnt;
    logic [3:0] hex_val;
    logic       hex_ok;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = i_byte[3:0];
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_val = i_byte[3:0];
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            hex_val = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        n_star    = r_star;
        n_xor     = r_xor;
        n_recv    = r_recv;
        n_hex_cnt = r_hex_cnt;
        if (i_step) begin
            if (!r_star) begin
                if (i_byte == nrmc_pkg::CH_STAR) begin
                    n_star = 1'b1;
                end else if (!i_pos_first) begin
                    n_xor = r_xor ^ i_byte;
                end
            end else if (r_hex_cnt < 2'd2) begin
                if (!hex_ok) begin
                    n_hex_cnt = 2'd3;
                end else begin
                    n_recv    = {r_recv[3:0], hex_val};
                    n_hex_cnt = r_hex_cnt + 2'd1;
                end
            end
        end
        o_stat.star_seen = r_star;
        o_stat.sum_ok    = !n_star || (n_xor == n_recv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_star    <= 1'b0;
            r_xor     <= '0;
            r_recv    <= '0;
            r_hex_cnt <= '0;
        end else if (i_step && i_last) begin
            r_star    <= 1'b0;
            r_xor     <= '0;
            r_recv    <= '0;
            r_hex_cnt <= '0;
        end else begin
            r_star    <= n_star;
            r_xor     <= n_xor;
            r_recv    <= n_recv;
            r_hex_cnt <= n_hex_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nrmc_numconv.sv =====
// one byte of bcd or saturating fixed-point conversion
`default_nettype none

module nrmc_numconv (
    input  wire logic [7:0]                         i_byte,
    input  wire nrmc_pkg::t_field_kind              i_kind,
    input  wire logic [nrmc_pkg::NUM_W-1:0]         i_value,
    input  wire nrmc_pkg::t_num_state               i_state,
    input  wire logic [nrmc_pkg::FRAC_W-1:0]        i_frac,
    input  wire logic [nrmc_pkg::NUM_W-1:0]         i_max,
    output logic [nrmc_pkg::NUM_W-1:0]              o_value,
    output nrmc_pkg::t_num_state                    o_state
);

    logic                                is_digit;
    logic [3:0]                          digit;
    logic [nrmc_pkg::DIG_W-1:0]          ndig;
    logic [nrmc_pkg::DIG_W-1:0]          nib;
    logic [nrmc_pkg::FRAC_W-1:0]         frac_inc;
    logic [nrmc_pkg::FRAC_W-1:0]         weight_idx;
    logic [27:0]                         weighted;
    logic [nrmc_pkg::WIDE_W-1:0]         base;
    logic [nrmc_pkg::WIDE_W-1:0]         sum;

    always_comb begin
        is_digit   = (i_byte >= nrmc_pkg::CH_ZERO) && (i_byte <= nrmc_pkg::CH_NINE);
        digit      = i_byte[3:0];
        ndig       = (i_kind == nrmc_pkg::FK_TIME) ? nrmc_pkg::TIME_DIGITS
                                                   : nrmc_pkg::DATE_DIGITS;
        nib        = ndig - i_state.dig_cnt - nrmc_pkg::DIG_W'(1);
        frac_inc   = i_state.frac_cnt + nrmc_pkg::FRAC_W'(1);
        // integer digits weigh 10^frac, fraction digits one place less each
        weight_idx = i_state.point ? (i_frac - frac_inc) : i_frac;
        weighted   = {24'd0, digit} * {4'd0, nrmc_pkg::pow10(weight_idx)};
        base       = i_state.point ? nrmc_pkg::WIDE_W'(i_value)
                                   : (nrmc_pkg::WIDE_W'(i_value) << 3)
                                     + (nrmc_pkg::WIDE_W'(i_value) << 1);
        sum        = base + nrmc_pkg::WIDE_W'(weighted);
    end

    always_comb begin
        o_value = i_value;
        o_state = i_state;
        if (!i_state.stop) begin
            unique case (i_kind) inside
                nrmc_pkg::FK_TIME, nrmc_pkg::FK_DATE: begin
                    if (is_digit) begin
                        if (i_state.dig_cnt < ndig) begin
                            o_value = i_value | (nrmc_pkg::NUM_W'(digit) << {nib, 2'b00});
                            o_state.dig_cnt = i_state.dig_cnt + nrmc_pkg::DIG_W'(1);
                        end
                    end else if (i_kind == nrmc_pkg::FK_TIME &&
                                 i_byte == nrmc_pkg::CH_POINT && !i_state.point) begin
                        o_state.point = 1'b1;
                    end else begin
                        o_state.stop = 1'b1;
                    end
                end
                nrmc_pkg::FK_DECIMAL: begin
                    if (is_digit) begin
                        if (!i_state.point || i_state.frac_cnt < i_frac) begin
                            if (i_state.point) begin
                                o_state.frac_cnt = frac_inc;
                            end
                            o_value = (sum > nrmc_pkg::WIDE_W'(i_max)) ? i_max
                                                                       : sum[nrmc_pkg::NUM_W-1:0];
                        end
                    end else if (i_byte == nrmc_pkg::CH_POINT && !i_state.point) begin
                        o_state.point = 1'b1;
                    end else begin
                        o_state.stop = 1'b1;
                    end
                end
                nrmc_pkg::FK_HEADER, nrmc_pkg::FK_CHAR: begin
                    o_value = i_value;
                end
                default: begin
                    o_value = i_value;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nrmc_fields.sv =====
// comma field tracking, header check, working and committed record
`default_nettype none

module nrmc_fields (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_last,
    input  wire nrmc_pkg::t_cks_stat i_cks,
    output logic                    o_pos_first,
    output nrmc_pkg::t_result       o_result
);

    logic [nrmc_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [nrmc_pkg::FIELD_W-1:0] r_field, n_field;
    logic                         r_hdr, n_hdr;
    logic                         r_started, n_started;
    nrmc_pkg::t_num_state         r_num, n_num;

    logic [nrmc_pkg::NUM_W-1:0] r_work_num [nrmc_pkg::NUM_SLOTS];
    logic [nrmc_pkg::NUM_W-1:0] n_work_num [nrmc_pkg::NUM_SLOTS];
    logic [7:0]                 r_work_chr [nrmc_pkg::CHR_SLOTS];
    logic [7:0]                 n_work_chr [nrmc_pkg::CHR_SLOTS];
    logic [nrmc_pkg::NUM_W-1:0] r_kept_num [nrmc_pkg::NUM_SLOTS];
    logic [7:0]                 r_kept_chr [nrmc_pkg::CHR_SLOTS];
    logic [nrmc_pkg::NUM_W-1:0] c_kept_num [nrmc_pkg::NUM_SLOTS];
    logic [7:0]                 c_kept_chr [nrmc_pkg::CHR_SLOTS];

    nrmc_pkg::t_field_kind         kind;
    logic [nrmc_pkg::NSLOT_W-1:0]  nslot;
    logic [nrmc_pkg::CSLOT_W-1:0]  cslot;
    logic [nrmc_pkg::NUM_W-1:0]    conv_base;
    logic [nrmc_pkg::NUM_W-1:0]    conv_value;
    nrmc_pkg::t_num_state          conv_state;
    logic                          parse_en;
    logic                          hdr_final;
    logic                          ok;

    assign kind        = nrmc_pkg::field_kind(r_field);
    assign nslot       = nrmc_pkg::num_slot(r_field);
    assign cslot       = nrmc_pkg::chr_slot(r_field);
    assign conv_base   = r_started ? r_work_num[nslot] : '0;
    assign o_pos_first = (r_pos == '0);

    nrmc_numconv u_conv (
        .i_byte  (i_byte),
        .i_kind  (kind),
        .i_value (conv_base),
        .i_state (r_num),
        .i_frac  (nrmc_pkg::dec_frac(r_field)),
        .i_max   (nrmc_pkg::dec_max(r_field)),
        .o_value (conv_value),
        .o_state (conv_state)
    );

    always_comb begin
        n_pos      = r_pos;
        n_field    = r_field;
        n_hdr      = r_hdr;
        n_started  = r_started;
        n_num      = r_num;
        n_work_num = r_work_num;
        n_work_chr = r_work_chr;
        parse_en   = !i_cks.star_seen && (i_byte != nrmc_pkg::CH_STAR) &&
                     (r_pos < nrmc_pkg::POS_LIMIT);
        if (i_step) begin
            // a star inside the header field fails the header
            if (!i_cks.star_seen && i_byte == nrmc_pkg::CH_STAR &&
                r_field == nrmc_pkg::F_HEADER) begin
                n_hdr = 1'b0;
            end
            if (parse_en) begin
                if (i_byte == nrmc_pkg::CH_COMMA && r_field < nrmc_pkg::F_MODE) begin
                    if (r_field == nrmc_pkg::F_HEADER && r_pos != nrmc_pkg::HEADER_LEN) begin
                        n_hdr = 1'b0;
                    end
                    n_field   = r_field + nrmc_pkg::FIELD_W'(1);
                    n_started = 1'b0;
                    n_num     = '0;
                end else begin
                    unique case (kind) inside
                        nrmc_pkg::FK_HEADER: begin
                            if (r_pos >= nrmc_pkg::HEADER_LEN ||
                                i_byte != nrmc_pkg::header_char(r_pos[2:0])) begin
                                n_hdr = 1'b0;
                            end
                        end
                        nrmc_pkg::FK_CHAR: begin
                            if (!r_started) begin
                                n_work_chr[cslot] = i_byte;
                            end
                            n_started = 1'b1;
                        end
                        nrmc_pkg::FK_TIME, nrmc_pkg::FK_DATE, nrmc_pkg::FK_DECIMAL: begin
                            n_work_num[nslot] = conv_value;
                            n_num             = conv_state;
                            n_started         = 1'b1;
                        end
                        default: begin
                            n_started = r_started;
                        end
                    endcase
                end
            end
            if (r_pos < nrmc_pkg::POS_LIMIT) begin
                n_pos = r_pos + nrmc_pkg::POS_W'(1);
            end
        end
    end

    // commit decision for a closing byte
    always_comb begin
        hdr_final = n_hdr && !(n_field == nrmc_pkg::F_HEADER &&
                               r_pos < nrmc_pkg::HEADER_MIN_END);
        ok        = hdr_final && i_cks.sum_ok;
        if (ok) begin
            c_kept_num = n_work_num;
            c_kept_chr = n_work_chr;
        end else begin
            c_kept_num = r_kept_num;
            c_kept_chr = r_kept_chr;
        end

        o_result.ok                 = ok;
        o_result.rec.time_bcd       = c_kept_num[nrmc_pkg::S_TIME][31:0];
        o_result.rec.fix_status     = c_kept_chr[nrmc_pkg::C_STATUS];
        o_result.rec.latitude       = c_kept_num[nrmc_pkg::S_LAT][29:0];
        o_result.rec.lat_hemisphere = c_kept_chr[nrmc_pkg::C_LAT_HEM];
        o_result.rec.longitude      = c_kept_num[nrmc_pkg::S_LON];
        o_result.rec.lon_hemisphere = c_kept_chr[nrmc_pkg::C_LON_HEM];
        o_result.rec.ground_speed   = c_kept_num[nrmc_pkg::S_SPEED][23:0];
        o_result.rec.heading        = c_kept_num[nrmc_pkg::S_HEADING][23:0];
        o_result.rec.date_bcd       = c_kept_num[nrmc_pkg::S_DATE][23:0];
        o_result.rec.fix_mode       = c_kept_chr[nrmc_pkg::C_MODE];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_field    <= nrmc_pkg::F_HEADER;
            r_hdr      <= 1'b1;
            r_started  <= 1'b0;
            r_num      <= '0;
            r_work_num <= '{default: '0};
            r_work_chr <= '{default: '0};
            r_kept_num <= '{default: '0};
            r_kept_chr <= '{default: '0};
        end else if (i_step && i_last) begin
            r_pos      <= '0;
            r_field    <= nrmc_pkg::F_HEADER;
            r_hdr      <= 1'b1;
            r_started  <= 1'b0;
            r_num      <= '0;
            r_work_num <= c_kept_num;
            r_work_chr <= c_kept_chr;
            r_kept_num <= c_kept_num;
            r_kept_chr <= c_kept_chr;
        end else begin
            r_pos      <= n_pos;
            r_field    <= n_field;
            r_hdr      <= n_hdr;
            r_started  <= n_started;
            r_num      <= n_num;
            r_work_num <= n_work_num;
            r_work_chr <= n_work_chr;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nmea_rmc_sentence_parser_core.sv =====
// top level of the streaming rmc sentence parser
`default_nettype none

// GNRMC sentence parser. Feed one sentence character per item, starting at
// '$', with i_last high on the final character. Each item passes through an
// input register and then a single update of the parse state (field counter,
// header check, xor checksum, one number converter shared by all numeric
// fields), so a new item can be accepted every cycle while the input side is
// not held. The final character of a sentence produces one result item via
// the input register and the result register: o_ok says the header read
// "$GNRMC" and the checksum after '*' matched (or no star was sent), and the
// record fields always show the last committed sentence, which is replaced
// only when ok is high. Empty fields keep their previous value. Only a final
// character that meets a full, stalled result register holds the input side;
// other characters keep flowing. There are no configuration registers and no
// clearing pass after reset; the committed record starts at zero.
module nmea_rmc_sentence_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // character input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_byte_req,
    input  wire logic        i_last,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_ok,
    output logic [31:0]      o_time_bcd,
    output logic [7:0]       o_fix_status,
    output logic [29:0]      o_latitude,
    output logic [7:0]       o_lat_hemisphere,
    output logic [33:0]      o_longitude,
    output logic [7:0]       o_lon_hemisphere,
    output logic [23:0]      o_ground_speed,
    output logic [23:0]      o_heading,
    output logic [23:0]      o_date_bcd,
    output logic [7:0]       o_fix_mode
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic               r_out_valid;
    nrmc_pkg::t_result  r_out;

    logic               hold;
    logic               step;
    logic               pos_first;
    nrmc_pkg::t_cks_stat cks_stat;
    nrmc_pkg::t_result  result;

    // a closing item cannot move on while the previous result sits unclaimed
    assign hold    = r_in_valid && r_in_last && r_out_valid && i_stall;
    assign step    = r_in_valid && !hold;
    assign o_stall = hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!hold) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold && i_valid) begin
            r_in_byte <= i_byte_req;
            r_in_last <= i_last;
        end
    end

    nrmc_cksum u_cksum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_pos_first (pos_first),
        .o_stat      (cks_stat)
    );

    nrmc_fields u_fields (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_cks       (cks_stat),
        .o_pos_first (pos_first),
        .o_result    (result)
    );

    // result register: loads on a closing item, empties when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_ok             = r_out.ok;
    assign o_time_bcd       = r_out.rec.time_bcd;
    assign o_fix_status     = r_out.rec.fix_status;
    assign o_latitude       = r_out.rec.latitude;
    assign o_lat_hemisphere = r_out.rec.lat_hemisphere;
    assign o_longitude      = r_out.rec.longitude;
    assign o_lon_hemisphere = r_out.rec.lon_hemisphere;
    assign o_ground_speed   = r_out.rec.ground_speed;
    assign o_heading        = r_out.rec.heading;
    assign o_date_bcd       = r_out.rec.date_bcd;
    assign o_fix_mode       = r_out.rec.fix_mode;

endmodule

`default_nettype wire

// ===== rtl/core/nrmc_checker.sv =====
// port-level checks of the rmc sentence parser and their bind
`default_nettype none

`include "assert_macros.svh"

module nrmc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        i_last,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_ok,
    input wire logic [31:0] o_time_bcd,
    input wire logic [33:0] o_longitude
);

    // input side only holds back behind an unclaimed result
    `NRMC_ASSERT_IMPL(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid)

    // a fresh result comes from a closing item accepted at the input, by way of the input register
    `NRMC_ASSERT_IMPL(a_result_from_last, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && !o_stall && i_last, 2))

    // an unclaimed result stays put
    `NRMC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_ok) && $stable(o_time_bcd) && $stable(o_longitude))

    `NRMC_ASSERT_RESET(a_reset_empty, i_clk, i_rst_n, !o_valid)

endmodule

bind nmea_rmc_sentence_parser_core nrmc_checker u_nrmc_checker (.*);

`default_nettype wire
